/* rtl/nts_pkg.sv */
// Shared types and constants for the nearest timestamp table.
// No dependencies; every other file of the block but nts_ram refers to it by scoped names.
`timescale 1ns / 1ps

package nts_pkg;

  // Table geometry
  localparam int unsigned TableDepth = 256;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);

  // Item operation codes
  typedef enum logic {
    OpInsert = 1'b0,
    OpQuery  = 1'b1
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusEmpty = 2'd1,
    StatusFull  = 2'd2
  } status_e;

  // One stored track point
  typedef struct packed {
    logic [31:0]        key;
    logic signed [30:0] lat;
    logic signed [31:0] lon;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // One incoming request as seen by the table walker
  typedef struct packed {
    op_e                op;
    logic [31:0]        item_time;
    logic signed [30:0] lat;
    logic signed [31:0] lon;
  } req_t;

  // One result
  typedef struct packed {
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    status_e            status;
  } res_t;

  // Write side of the table memory
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] addr;
    entry_t          data;
  } mem_wr_t;

endpackage

/* rtl/nts_if.sv */
// Handshake channels of the nearest timestamp table: requests, results, offset writes.
// Depends on nts_pkg for the opcode and status types.
`timescale 1ns / 1ps

interface nts_item_if;
  logic               valid;
  logic               ready;
  nts_pkg::op_e       opcode;
  logic [31:0]        item_time;
  logic signed [30:0] lat_in;
  logic signed [31:0] lon_in;

  modport source (output valid, opcode, item_time, lat_in, lon_in, input ready);
  modport sink   (input valid, opcode, item_time, lat_in, lon_in, output ready);
endinterface

interface nts_result_if;
  logic               valid;
  logic               ready;
  logic signed [30:0] lat_out;
  logic signed [31:0] lon_out;
  nts_pkg::status_e   status;

  modport source (output valid, lat_out, lon_out, status, input ready);
  modport sink   (input valid, lat_out, lon_out, status, output ready);
endinterface

interface nts_cfg_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] time_offset;

  modport source (output valid, time_offset, input ready);
  modport sink   (input valid, time_offset, output ready);
endinterface

/* rtl/nts_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module nts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/nts_walk.sv */
// Table walker: scans the sorted table one entry a cycle for inserts and lookups.
// Depends on nts_pkg; drives the table memory held in nts_ram.
`timescale 1ns / 1ps

module nts_walk (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  output logic                         req_ready_o,
  input  nts_pkg::req_t                req_i,
  input  logic signed [31:0]           time_offset_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output nts_pkg::res_t                res_o,
  output nts_pkg::mem_wr_t             mem_wr_o,
  output logic [nts_pkg::IdxW-1:0]     mem_raddr_o,
  input  nts_pkg::entry_t              mem_rdata_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]                 state_q, state_d;
  logic [nts_pkg::CntW-1:0]   idx_q, idx_d;
  logic [nts_pkg::CntW-1:0]   count_q, count_d;
  logic                       placed_q, placed_d;
  nts_pkg::req_t              req_q;
  logic signed [33:0]         qtime_q, qtime_d;
  nts_pkg::entry_t            carry_q, carry_d;
  nts_pkg::res_t              res_q, res_d;

  logic                       accept;
  logic                       at_end;
  logic                       full;
  nts_pkg::entry_t            cur;
  nts_pkg::entry_t            new_entry;
  logic signed [33:0]         cur_time;
  logic signed [33:0]         prev_time;
  logic signed [33:0]         above;
  logic signed [33:0]         below;

  assign accept      = req_valid_i && (state_q == StIdle);
  assign req_ready_o = (state_q == StIdle);
  assign res_valid_o = (state_q == StDone);
  assign res_o       = res_q;

  assign at_end    = (idx_q == count_q);
  assign full      = (count_q == nts_pkg::CntW'(nts_pkg::TableDepth));
  assign cur       = mem_rdata_i;
  assign new_entry = '{key: req_q.item_time, lat: req_q.lat, lon: req_q.lon};
  assign cur_time  = $signed({2'b00, cur.key});
  assign prev_time = $signed({2'b00, carry_q.key});
  assign above     = cur_time - qtime_q;
  assign below     = qtime_q - prev_time;

  // query time, exact in 34 bits
  assign qtime_d = $signed({2'b00, req_i.item_time})
                 - $signed({{2{time_offset_i[31]}}, time_offset_i});

  // next address to read is the entry handled next cycle
  assign mem_raddr_o = idx_d[nts_pkg::IdxW-1:0];

  // walk control
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    count_d  = count_q;
    placed_d = placed_q;
    carry_d  = carry_q;
    res_d    = res_q;
    mem_wr_o = '{we: 1'b0, addr: idx_q[nts_pkg::IdxW-1:0], data: new_entry};

    unique case (state_q)
      StIdle: begin
        idx_d    = '0;
        placed_d = 1'b0;
        if (req_valid_i) begin
          if (req_i.op == nts_pkg::OpQuery && count_q == '0) begin
            res_d   = '{lat: '0, lon: '0, status: nts_pkg::StatusEmpty};
            state_d = StDone;
          end else begin
            state_d = StScan;
          end
        end
      end

      StScan: begin
        if (req_q.op == nts_pkg::OpInsert) begin
          // insert: find slot, then ripple displaced entries up by one
          priority if (at_end) begin
            res_d   = '{lat: '0, lon: '0, status: nts_pkg::StatusOk};
            state_d = StDone;
            if (placed_q) begin
              mem_wr_o.we   = 1'b1;
              mem_wr_o.data = carry_q;
              count_d       = count_q + 1'b1;
            end else if (full) begin
              res_d.status = nts_pkg::StatusFull;
            end else begin
              mem_wr_o.we = 1'b1;
              count_d     = count_q + 1'b1;
            end
          end else if (placed_q) begin
            mem_wr_o.we   = 1'b1;
            mem_wr_o.data = carry_q;
            carry_d       = cur;
            idx_d         = idx_q + 1'b1;
          end else if (cur.key == req_q.item_time) begin
            // same timestamp: overwrite position only
            mem_wr_o.we = 1'b1;
            res_d       = '{lat: '0, lon: '0, status: nts_pkg::StatusOk};
            state_d     = StDone;
          end else if (cur.key > req_q.item_time) begin
            if (full) begin
              res_d   = '{lat: '0, lon: '0, status: nts_pkg::StatusFull};
              state_d = StDone;
            end else begin
              mem_wr_o.we = 1'b1;
              carry_d     = cur;
              placed_d    = 1'b1;
              idx_d       = idx_q + 1'b1;
            end
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else begin
          // query: carry holds the previous entry
          priority if (at_end) begin
            res_d   = '{lat: carry_q.lat, lon: carry_q.lon, status: nts_pkg::StatusOk};
            state_d = StDone;
          end else if (cur_time >= qtime_q) begin
            state_d = StDone;
            if (idx_q == '0 || above < below) begin
              res_d = '{lat: cur.lat, lon: cur.lon, status: nts_pkg::StatusOk};
            end else begin
              res_d = '{lat: carry_q.lat, lon: carry_q.lon, status: nts_pkg::StatusOk};
            end
          end else begin
            carry_d = cur;
            idx_d   = idx_q + 1'b1;
          end
        end
      end

      StDone: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      idx_q    <= '0;
      count_q  <= '0;
      placed_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      count_q  <= count_d;
      placed_q <= placed_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= req_i;
      qtime_q <= qtime_d;
    end
    carry_q <= carry_d;
    res_q   <= res_d;
  end

endmodule

/* rtl/nearest_timestamp_table.sv */
// Top level of the nearest timestamp table: channels, offset register, output stage.
// Depends on nts_pkg, nts_if, nts_ram and nts_walk.
`timescale 1ns / 1ps
//
// Usage
//   item_i   : requests. opcode 0 inserts (item_time, lat_in, lon_in) into a
//              table kept sorted by time; an equal time overwrites that point.
//              opcode 1 looks up the point nearest to item_time - time_offset.
//   result_o : exactly one result per request, in request order. Inserts give
//              zero position with status ok or full; lookups give the point's
//              position, or status empty on an empty table.
//   cfg_i    : writes time_offset; always ready. Write it only while idle.
// Timing
//   A request walks the table memory one entry a cycle through its single read
//   port. One request is in work at a time; item_i.ready is high whenever the
//   walker is free.
//   The result sits in an output register, so the next request is taken while
//   a result waits; a stalled receiver holds the walker only after that.
// Reset
//   The table is empty and time_offset is zero. No memory clearing is needed.

module nearest_timestamp_table (
  input  logic          clk_i,
  input  logic          rst_ni,
  nts_item_if.sink      item_i,
  nts_result_if.source  result_o,
  nts_cfg_if.sink       cfg_i
);

  logic signed [31:0]           offset_q;
  nts_pkg::req_t                req;
  logic                         res_valid;
  logic                         res_ready;
  nts_pkg::res_t                res;
  nts_pkg::mem_wr_t             mem_wr;
  logic [nts_pkg::IdxW-1:0]     mem_raddr;
  logic [nts_pkg::EntryW-1:0]   mem_rdata;
  logic                         out_valid_q;
  nts_pkg::res_t                out_q;

  // offset register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (cfg_i.valid) begin
      offset_q <= cfg_i.time_offset;
    end
  end

  assign req = '{op: item_i.opcode, item_time: item_i.item_time,
                 lat: item_i.lat_in, lon: item_i.lon_in};

  // table walker
  nts_walk u_walk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (item_i.valid),
    .req_ready_o   (item_i.ready),
    .req_i         (req),
    .time_offset_i (offset_q),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .mem_wr_o      (mem_wr),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (nts_pkg::entry_t'(mem_rdata))
  );

  // table memory
  nts_ram #(
    .Width (nts_pkg::EntryW),
    .Depth (nts_pkg::TableDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_wr.we),
    .waddr_i (mem_wr.addr),
    .wdata_i (mem_wr.data),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register
  assign res_ready = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.lat_out = out_q.lat;
  assign result_o.lon_out = out_q.lon;
  assign result_o.status  = out_q.status;

endmodule

/* rtl/nts_checker.sv */
// Port-level checks for the nearest timestamp table, bound to the top level.
// Depends on nts_pkg for the status codes.
`timescale 1ns / 1ps

module nts_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               item_valid_i,
  input logic               item_ready_i,
  input logic               res_valid_i,
  input logic               res_ready_i,
  input logic signed [30:0] lat_i,
  input logic signed [31:0] lon_i,
  input nts_pkg::status_e   status_i
);

  // a held result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  // a held result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(lat_i) && $stable(lon_i) && $stable(status_i))
    else $error("result payload changed while stalled");

  // one request in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_i && item_ready_i |=> !item_ready_i)
    else $error("second request taken while busy");

  // error results carry no position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && status_i != nts_pkg::StatusOk |-> lat_i == '0 && lon_i == '0)
    else $error("error result with a position");

  // status is never the unused code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> status_i == nts_pkg::StatusOk || status_i == nts_pkg::StatusEmpty
                    || status_i == nts_pkg::StatusFull)
    else $error("bad result status");

endmodule

bind nearest_timestamp_table nts_checker u_nts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .item_valid_i (item_i.valid),
  .item_ready_i (item_i.ready),
  .res_valid_i  (result_o.valid),
  .res_ready_i  (result_o.ready),
  .lat_i        (result_o.lat_out),
  .lon_i        (result_o.lon_out),
  .status_i     (result_o.status)
);
